// File: hdl/iqbsu_pkg.sv
package iqbsu_pkg;

  localparam int OUT_BITS_DEF     = 16;
  localparam int OUT_BITS_WIDE    = 24;

  localparam int DATA_W           = 8;
  localparam int CBYTES_W         = 3;
  localparam int POS_W            = 2;
  localparam int PART_W           = 24;
  localparam int SAMPLE_W         = 32;

  localparam logic [CBYTES_W-1:0] CBYTES_RST = 3'd1;
  localparam logic [CBYTES_W-1:0] CBYTES_8   = 3'd1;
  localparam logic [CBYTES_W-1:0] CBYTES_16  = 3'd2;
  localparam logic [CBYTES_W-1:0] CBYTES_24  = 3'd3;
  localparam logic [CBYTES_W-1:0] CBYTES_32  = 3'd4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// File: hdl/iq_byte_stream_sample_unpacker_top.sv
// IQ byte stream sample unpacker.
// Input channel (in_valid/in_ready): one stream byte per request, with
// in_last_byte marking the final byte of a batch. Bytes gather little endian
// into components of cfg_wr_data bytes (1..4; other values drop all bytes).
// Output channel (out_valid/out_ready): one signed component, scaled to
// OUT_BITS (16 or 24), alternating I then Q, with out_last_sample set when
// the completing byte carried the batch mark.
// Configuration: cfg_wr_en writes the component size and restarts assembly
// at an I component; write only while the block is idle.
// Output: a result is registered and appears in the cycle after its completing byte is taken.
// Throughput: one byte per cycle, set by the single output register; a byte
// is still taken while a result waits, as long as out_ready is high or the
// output register is empty.
// Stall: with out_valid high and out_ready low, the result holds and
// in_ready drops until it is taken.
// Reset (rst_n low, synchronous): size 1 byte, assembly cleared, next
// component is I, output empty.
module iq_byte_stream_sample_unpacker_top #(
  parameter int OUT_BITS = iqbsu_pkg::OUT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [iqbsu_pkg::CBYTES_W-1:0]      cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [iqbsu_pkg::DATA_W-1:0]        in_data_byte,
  input  logic                                in_last_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [iqbsu_pkg::SAMPLE_W-1:0] out_sample_value,
  output logic                                out_is_quadrature,
  output logic                                out_last_sample
);
  import iqbsu_pkg::*;

  localparam bit WIDE = (OUT_BITS == OUT_BITS_WIDE);

  logic [CBYTES_W-1:0] cbytes_r;
  logic [POS_W-1:0]    pos_r,  pos_nxt;
  logic [PART_W-1:0]   part_r, part_nxt;
  logic                quad_r, quad_nxt;
  logic                out_valid_r, out_valid_nxt;
  sample_t             sample_r, sample_nxt;
  logic                oquad_r, olast_r;

  logic                in_fire, width_ok, complete;
  logic [SAMPLE_W-1:0] word;
  logic [CBYTES_W-1:0] pos_inc;
  logic signed [7:0]   s8;
  logic signed [15:0]  s16_lo, s16_hi;
  logic signed [23:0]  s24;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign width_ok = (cbytes_r != '0) && (cbytes_r <= CBYTES_32);
  assign pos_inc  = {1'b0, pos_r} + CBYTES_W'(1);
  assign complete = width_ok && (pos_inc >= cbytes_r);

  // new byte placed at its little-endian slot
  assign word = {8'd0, part_r} | (SAMPLE_W'(in_data_byte) << {pos_r, 3'b000});

  assign s8     = {~word[7], word[6:0]};
  assign s16_lo = word[15:0];
  assign s16_hi = word[23:8];
  assign s24    = word[23:0];

  always_comb begin
    case (cbytes_r)
      CBYTES_8:  sample_nxt = WIDE ? (sample_t'(s8) <<< 16) : (sample_t'(s8) <<< 8);
      CBYTES_16: sample_nxt = WIDE ? (sample_t'(s16_lo) <<< 8) : sample_t'(s16_lo);
      CBYTES_24: sample_nxt = WIDE ? sample_t'(s24) : sample_t'(s16_hi);
      CBYTES_32: sample_nxt = WIDE ? sample_t'(word) : sample_t'(s16_hi);
      default:   sample_nxt = '0;
    endcase
  end

  always_comb begin
    pos_nxt       = pos_r;
    part_nxt      = part_r;
    quad_nxt      = quad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cfg_wr_en) begin
      pos_nxt  = '0;
      part_nxt = '0;
      quad_nxt = 1'b0;
    end else if (in_fire && width_ok) begin
      if (complete) begin
        pos_nxt       = '0;
        part_nxt      = '0;
        quad_nxt      = !quad_r;
        out_valid_nxt = 1'b1;
      end else begin
        pos_nxt  = pos_inc[POS_W-1:0];
        part_nxt = word[PART_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cbytes_r    <= CBYTES_RST;
      pos_r       <= '0;
      part_r      <= '0;
      quad_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cbytes_r <= cfg_wr_data;
      end
      pos_r       <= pos_nxt;
      part_r      <= part_nxt;
      quad_r      <= quad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && complete && !cfg_wr_en) begin
      sample_r <= sample_nxt;
      oquad_r  <= quad_r;
      olast_r  <= in_last_byte;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_value  = sample_r;
  assign out_is_quadrature = oquad_r;
  assign out_last_sample   = olast_r;

`ifndef SYNTHESIS
  a_pos_below_size: assert property (@(posedge clk) disable iff (!rst_n)
    width_ok |-> ({1'b0, pos_r} < cbytes_r))
    else $error("byte position reached component size");

  a_complete_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && complete && !cfg_wr_en) |=>
      (out_valid && out_is_quadrature == !quad_r && pos_r == '0))
    else $error("completed component not presented");

  a_partial_keeps_iq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !complete && !cfg_wr_en) |=> $stable(quad_r))
    else $error("I/Q toggled without a completed component");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (pos_r == '0 && part_r == '0 && !quad_r))
    else $error("size write did not restart assembly");
`endif

endmodule

// File: sim/iq_sample_checker.sv
module iq_sample_checker #(
  parameter int OUT_BITS = iqbsu_pkg::OUT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [iqbsu_pkg::CBYTES_W-1:0] cfg_wr_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [iqbsu_pkg::DATA_W-1:0]   in_data_byte,
  input  logic                           in_last_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  iqbsu_pkg::sample_t             out_sample_value,
  input  logic                           out_is_quadrature,
  input  logic                           out_last_sample,
  output int                             error_count,
  output int                             pending_count,
  output int                             bytes_taken,
  output int                             components_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import iqbsu_pkg::*;

  typedef struct packed {
    sample_t value;
    logic    quad;
    logic    last;
  } component_t;

  component_t          awaited_components[$];
  logic [CBYTES_W-1:0] width_sel;
  logic [POS_W-1:0]    gathered;
  logic [PART_W-1:0]   partial;
  logic                next_is_q;

  function automatic sample_t scale_component(logic [SAMPLE_W-1:0] word,
                                              logic [CBYTES_W-1:0] n);
    logic signed [15:0] lo16;
    logic signed [15:0] mid16;
    logic signed [23:0] lo24;
    int                 offs;
    int                 v_lo16;
    int                 v_mid16;
    int                 v_lo24;
    bit                 wide;
    wide    = (OUT_BITS == OUT_BITS_WIDE);
    lo16    = word[15:0];
    mid16   = word[23:8];
    lo24    = word[23:0];
    v_lo16  = lo16;
    v_mid16 = mid16;
    v_lo24  = lo24;
    offs    = int'(word[7:0]) - 128;
    case (n)
      CBYTES_8:  scale_component = wide ? offs * 65536 : offs * 256;
      CBYTES_16: scale_component = wide ? v_lo16 * 256 : v_lo16;
      CBYTES_24: scale_component = wide ? v_lo24 : v_mid16;
      default:   scale_component = wide ? sample_t'(word) : v_mid16;
    endcase
  endfunction

  always @(posedge clk) begin
    component_t          want;
    logic [SAMPLE_W-1:0] word;
    if (!rst_n) begin
      width_sel = CBYTES_RST;
      gathered  = '0;
      partial   = '0;
      next_is_q = 1'b0;
      awaited_components.delete();
    end else begin
      // size write restarts assembly at an I component
      if (cfg_wr_en) begin
        width_sel = cfg_wr_data;
        gathered  = '0;
        partial   = '0;
        next_is_q = 1'b0;
      end
      if (out_valid && out_ready) begin
        components_seen++;
        if (awaited_components.size() == 0) begin
          error_count++;
          $display("%0t: unexpected component, expected none, got value %0d q %0b last %0b",
                   $time, out_sample_value, out_is_quadrature, out_last_sample);
        end else begin
          want = awaited_components.pop_front();
          if (out_sample_value !== want.value) begin
            error_count++;
            $display("%0t: sample_value expected %0d got %0d",
                     $time, want.value, out_sample_value);
          end
          if (out_is_quadrature !== want.quad) begin
            error_count++;
            $display("%0t: is_quadrature expected %0b got %0b",
                     $time, want.quad, out_is_quadrature);
          end
          if (out_last_sample !== want.last) begin
            error_count++;
            $display("%0t: last_sample expected %0b got %0b",
                     $time, want.last, out_last_sample);
          end
        end
      end
      if (in_valid && in_ready) begin
        bytes_taken++;
        // bytes are dropped for sizes outside 1..4
        if (width_sel >= CBYTES_8 && width_sel <= CBYTES_32) begin
          word = {8'h00, partial} | ({24'h000000, in_data_byte} << (8 * gathered));
          if (gathered + 1 < width_sel) begin
            partial  = word[PART_W-1:0];
            gathered = gathered + 1'b1;
          end else begin
            awaited_components.push_back(
              '{scale_component(word, width_sel), next_is_q, in_last_byte});
            next_is_q = ~next_is_q;
            gathered  = '0;
            partial   = '0;
          end
        end
      end
    end
    pending_count = awaited_components.size();
  end

endmodule

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import iqbsu_pkg::*;

  localparam int OUT_BITS = OUT_BITS_DEF;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                cfg_wr_en    = 1'b0;
  logic [CBYTES_W-1:0] cfg_wr_data  = CBYTES_RST;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [DATA_W-1:0]   in_data_byte = '0;
  logic                in_last_byte = 1'b0;
  logic                out_valid;
  logic                out_ready    = 1'b1;
  sample_t             out_sample_value;
  logic                out_is_quadrature;
  logic                out_last_sample;

  int   error_count;
  int   pending_count;
  int   bytes_taken;
  int   components_seen;
  int   width_writes = 0;
  int   sized_bytes  = 0;
  logic quiet        = 1'b0;

  iq_byte_stream_sample_unpacker_top #(.OUT_BITS(OUT_BITS)) dut (.*);

  iq_sample_checker #(.OUT_BITS(OUT_BITS)) checker_i (.*);

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_ready = quiet || ($urandom_range(99) >= 7);
  end

  task automatic push_byte(input logic [DATA_W-1:0] d, input logic l);
    int gap;
    if (!quiet && $urandom_range(99) < 7) begin
      in_valid = 1'b0;
      gap = $urandom_range(3, 1);
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data_byte = d;
    in_last_byte = l;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (cfg_wr_data >= CBYTES_8 && cfg_wr_data <= CBYTES_32) sized_bytes++;
  endtask

  // hold the sender until every expected component is out, then let the pipe empty
  task automatic settle();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_width(input logic [CBYTES_W-1:0] w);
    settle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = w;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    width_writes++;
  endtask

  initial begin
    logic [CBYTES_W-1:0] w;
    logic [CBYTES_W-1:0] first_widths[8];
    int                  phase;
    int                  count;
    first_widths = '{CBYTES_8, CBYTES_16, CBYTES_24, CBYTES_32,
                     3'd0, 3'd7, 3'd5, 3'd6};
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset size: 8-bit offset binary
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(8'hff, 1'b1);

    write_width(CBYTES_16);
    push_byte(8'h00, 1'b1);  // mark mid-component is ignored
    push_byte(8'h80, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h7f, 1'b1);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);

    write_width(CBYTES_24);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h7f, 1'b1);

    write_width(CBYTES_32);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(8'hff, 1'b0);  // partial component, dropped by the next write

    write_width(3'd0);
    push_byte(8'h55, 1'b1);
    write_width(3'd7);
    push_byte(8'haa, 1'b0);

    phase = 0;
    while (sized_bytes < 900) begin
      if (phase < 8) begin
        w = first_widths[phase];
      end else if (phase != 9 && $urandom_range(9) == 0) begin
        w = ($urandom_range(1) == 0) ? 3'd0 : CBYTES_W'($urandom_range(7, 5));
      end else begin
        w = CBYTES_W'($urandom_range(4, 1));
      end
      write_width(w);
      quiet = (phase == 9 && w != 3'd0 && w <= CBYTES_32);
      if (quiet) count = 150;
      else if (w == 3'd0 || w > CBYTES_32) count = $urandom_range(8, 2);
      else count = $urandom_range(90, 20);
      repeat (count) push_byte(DATA_W'($urandom_range(255)), $urandom_range(9) == 0);
      quiet = 1'b0;
      phase++;
    end

    settle();
    $display("covered %0d bytes over %0d size writes (all sizes 0..7), %0d components compared",
             bytes_taken, width_writes, components_seen);
    if (error_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("watchdog expired with %0d components outstanding", pending_count);
    $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
hdl/iqbsu_pkg.sv
hdl/iq_byte_stream_sample_unpacker_top.sv
sim/iq_sample_checker.sv
sim/tb_top.sv
